FILE: src/sha1_message_digest_defines.svh
// Assertion macros used by the SHA-1 round core.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SHA1_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SHA1_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: src/sha1_pkg.sv
`default_nettype none
package sha1_pkg;
	typedef logic [31:0] word_t;

	localparam int unsigned CountW = 61;
	localparam int unsigned Rounds = 80;

	localparam word_t IV0 = 32'h67452301;
	localparam word_t IV1 = 32'hefcdab89;
	localparam word_t IV2 = 32'h98badcfe;
	localparam word_t IV3 = 32'h10325476;
	localparam word_t IV4 = 32'hc3d2e1f0;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	localparam logic [7:0] PadByte = 8'h80;

	// Block image selection when a compression is started.
	localparam logic [1:0] MODE_DATA   = 2'd0;
	localparam logic [1:0] MODE_PAD    = 2'd1;
	localparam logic [1:0] MODE_PADLEN = 2'd2;
	localparam logic [1:0] MODE_LEN    = 2'd3;

	typedef struct packed {
		logic start;
		logic iv_load;
	} core_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;
endpackage
`default_nettype wire

FILE: src/sha1_core.sv
`default_nettype none
`include "sha1_message_digest_defines.svh"
module sha1_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha1_pkg::core_ctrl_t ctrl,
	input  wire logic [511:0]        block,
	output sha1_pkg::core_stat_t     stat,
	output logic [159:0]             chain
);
	logic                run_q, fin_q, done_q;
	logic [6:0]          round_q;
	sha1_pkg::word_t     sched_q [16];
	sha1_pkg::word_t     a_q, b_q, c_q, d_q, e_q;
	sha1_pkg::word_t     h_q [5];
	sha1_pkg::word_t     w, f, k, t, x;

	always_comb begin
		x = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
		w = (round_q < 7'd16) ? sched_q[0] : {x[30:0], x[31]};
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1_pkg::K0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + w + k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
			h_q[0]  <= sha1_pkg::IV0;
			h_q[1]  <= sha1_pkg::IV1;
			h_q[2]  <= sha1_pkg::IV2;
			h_q[3]  <= sha1_pkg::IV3;
			h_q[4]  <= sha1_pkg::IV4;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (ctrl.start) begin
				run_q   <= 1'b1;
				round_q <= '0;
			end else if (run_q) begin
				round_q <= round_q + 7'd1;
				if (round_q == 7'(sha1_pkg::Rounds - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end else if (ctrl.iv_load) begin
				h_q[0] <= sha1_pkg::IV0;
				h_q[1] <= sha1_pkg::IV1;
				h_q[2] <= sha1_pkg::IV2;
				h_q[3] <= sha1_pkg::IV3;
				h_q[4] <= sha1_pkg::IV4;
			end
		end
	end

	// Schedule window: slot 15 receives each round's word, slot 0 is oldest.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int j = 0; j < 16; j++) begin
				sched_q[j] <= block[511 - 32*j -: 32];
			end
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (run_q) begin
			for (int j = 0; j < 15; j++) begin
				sched_q[j] <= sched_q[j+1];
			end
			sched_q[15] <= w;
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end
	end

	assign stat.busy = run_q | fin_q;
	assign stat.done = done_q;
	assign chain = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

	`SHA1_NEVER(a_start_busy, ctrl.start && (run_q || fin_q), "start while compressing")
	`SHA1_ASSERT(a_fin_after_last, fin_q |-> $past(run_q) && ($past(round_q) == 7'd79), "bad finish")
	`SHA1_ASSERT(a_done_after_fin, done_q |-> $past(fin_q), "done without finish")
endmodule
`default_nettype wire

FILE: src/sha1_message_digest.sv
// A message byte that does not complete a block is taken without stalling the input.
// A byte that completes a 64-byte block is taken, then stalls the input while its 80 rounds run on one unit.
// End of message: the first digest word is offered once the final block is compressed, after
// an extra block when the length spills over, and after the full data block as well when the closing byte fills one.
// The input stays stalled while a block is compressed and while the digest words are offered.
// Reset: arst_n asynchronously clears control, the byte count and loads the initial vector.
`default_nettype none
module sha1_message_digest (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        msg_valid,
	output logic             msg_stall,
	input  wire logic [7:0]  msg_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                     state_q;
	logic [1:0]                     mode_q;
	logic                           last_q;
	logic [2:0]                     idx_q;
	logic [sha1_pkg::CountW-1:0]    count_q;
	// The partial block is held as sixteen big-endian words.
	sha1_pkg::word_t                blk_q [16];

	sha1_pkg::core_ctrl_t ctrl;
	sha1_pkg::core_stat_t stat;
	logic [159:0]         chain;
	logic [511:0]         image;
	logic [1:0]           start_mode;
	logic                 in_acc, out_acc, stored;
	logic [5:0]           off;
	logic [63:0]          bit_len;

	assign in_acc  = msg_valid & ~msg_stall;
	assign out_acc = digest_valid & ~digest_stall;
	assign off     = count_q[5:0];
	// Bytes past the saturated count are dropped.
	assign stored  = byte_present & ~(&count_q);
	assign bit_len = {count_q, 3'b000};

	// Start decisions: a full block on input, the padded final block(s).
	always_comb begin
		ctrl.start   = 1'b0;
		ctrl.iv_load = 1'b0;
		start_mode   = sha1_pkg::MODE_DATA;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && stored && off == 6'd63) begin
					ctrl.start = 1'b1;
				end
			end
			ST_PAD: begin
				ctrl.start = 1'b1;
				start_mode = (off > 6'd55) ? sha1_pkg::MODE_PAD : sha1_pkg::MODE_PADLEN;
			end
			ST_WAIT: begin
				if (stat.done && mode_q == sha1_pkg::MODE_PAD) begin
					ctrl.start = 1'b1;
					start_mode = sha1_pkg::MODE_LEN;
				end
			end
			ST_OUT: begin
				ctrl.iv_load = out_acc && idx_q == 3'd4;
			end
			default: begin
			end
		endcase
	end

	// Block image seen by the round unit. In the padding modes the byte at the
	// current offset becomes the pad marker and every later byte reads as zero,
	// so stale bytes from an earlier block never leak in.
	always_comb begin
		for (int i = 0; i < 64; i++) begin
			case (start_mode)
				sha1_pkg::MODE_DATA: image[511 - 8*i -: 8] = blk_q[i/4][31 - 8*(i%4) -: 8];
				sha1_pkg::MODE_LEN:  image[511 - 8*i -: 8] = 8'h00;
				default: begin
					if (6'(i) < off) begin
						image[511 - 8*i -: 8] = blk_q[i/4][31 - 8*(i%4) -: 8];
					end else if (6'(i) == off) begin
						image[511 - 8*i -: 8] = sha1_pkg::PadByte;
					end else begin
						image[511 - 8*i -: 8] = 8'h00;
					end
				end
			endcase
		end
		// A data block starts on the transaction that carries its last byte,
		// which is not in the buffer yet, so it is taken from the input.
		if (start_mode == sha1_pkg::MODE_DATA) begin
			image[7:0] = msg_byte;
		end
		// The bit length fills the last eight bytes of the final block.
		if (start_mode == sha1_pkg::MODE_PADLEN || start_mode == sha1_pkg::MODE_LEN) begin
			image[63:0] = bit_len;
		end
	end

	sha1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.block  (image),
		.stat   (stat),
		.chain  (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= sha1_pkg::MODE_DATA;
			last_q  <= 1'b0;
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.start) begin
				mode_q <= start_mode;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= end_of_message;
						if (stored) begin
							count_q <= count_q + 1'b1;
						end
						if (stored && off == 6'd63) begin
							state_q <= ST_WAIT;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (stat.done) begin
						case (mode_q)
							sha1_pkg::MODE_DATA: state_q <= last_q ? ST_PAD : ST_IDLE;
							sha1_pkg::MODE_PAD:  state_q <= ST_WAIT;
							default: begin
								state_q <= ST_OUT;
								idx_q   <= '0;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd4) begin
							state_q <= ST_IDLE;
							count_q <= '0;
							last_q  <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Byte buffer: written at the running offset, read only into the block image.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && stored) begin
			blk_q[off[5:2]][31 - 8*off[1:0] -: 8] <= msg_byte;
		end
	end

	assign msg_stall    = state_q != ST_IDLE;
	assign digest_valid = state_q == ST_OUT;
	assign word_index   = idx_q;
	assign last_word    = idx_q == 3'd4;

	always_comb begin
		case (idx_q)
			3'd0:    digest_word = chain[159:128];
			3'd1:    digest_word = chain[127:96];
			3'd2:    digest_word = chain[95:64];
			3'd3:    digest_word = chain[63:32];
			default: digest_word = chain[31:0];
		endcase
	end
endmodule
`default_nettype wire

FILE: tb/sha1_message_digest_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_digest_tb;

	// Cycle limit. The slowest correct run stays well under it: each
	// transaction may wait for a random gap, each block compression stalls
	// the input, and each digest word may be held off by the receiver.
	localparam int unsigned CycleLimit = 400000;
	// Length of the one long receiver hold-off right after reset.
	localparam int unsigned LongHold = 600;
	localparam int unsigned RandomItems = 400;
	localparam int unsigned MinDigestWords = 60;
	localparam logic [60:0] CountSat = {61{1'b1}};

	logic clk = 1'b0;
	logic arst_n;
	logic msg_valid;
	logic msg_stall;
	logic [7:0] msg_byte;
	logic byte_present;
	logic end_of_message;
	logic digest_valid;
	logic digest_stall;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;

	sha1_message_digest uut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg_byte(msg_byte),
		.byte_present(byte_present),
		.end_of_message(end_of_message),
		.digest_valid(digest_valid),
		.digest_stall(digest_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always #1 clk = ~clk;

	// One digest word as it should leave the block.
	typedef struct {
		sha1_pkg::word_t word;
		logic [2:0]      idx;
		logic            is_last;
	} digest_out_t;

	digest_out_t pending_words[$];

	// Shadow copy of the hash state: chaining words, the partial block and
	// the saturating byte count.
	sha1_pkg::word_t chain[5];
	logic [7:0]      block_bytes[64];
	logic [60:0]     msg_count;

	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int unsigned words_due = 0;
	// When set, both sides run without random gaps or hold-offs.
	bit calm = 1'b0;

	function automatic sha1_pkg::word_t rotl(sha1_pkg::word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Compress the 64-byte block image into the chaining words.
	task automatic compress_block();
		sha1_pkg::word_t sched[16];
		sha1_pkg::word_t a, b, c, d, e, f, k, t, w;
		for (int j = 0; j < 16; j++) begin
			sched[j] = {block_bytes[4*j], block_bytes[4*j+1],
				block_bytes[4*j+2], block_bytes[4*j+3]};
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int r = 0; r < sha1_pkg::Rounds; r++) begin
			if (r < 16) begin
				w = sched[r];
			end else begin
				w = rotl(sched[(r+13)%16] ^ sched[(r+8)%16] ^ sched[(r+2)%16] ^ sched[r%16], 1);
				sched[r%16] = w;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d); k = sha1_pkg::K0;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = sha1_pkg::K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = sha1_pkg::K3;
			end
			t = rotl(a, 5) + f + e + w + k;
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	task automatic restart_hash();
		chain = '{sha1_pkg::IV0, sha1_pkg::IV1, sha1_pkg::IV2, sha1_pkg::IV3, sha1_pkg::IV4};
		msg_count = '0;
	endtask

	// Advance the shadow hash by one accepted transaction and queue the
	// digest words it produces. A nonzero known digest replaces the
	// predicted one, so those words are checked against the known value.
	task automatic absorb_item(logic [7:0] data, logic present, logic eom,
			logic [159:0] known);
		int unsigned off;
		logic [63:0] bit_len;
		digest_out_t dw;
		// Bytes past the saturated count are dropped; the count cannot get
		// there in a simulation, but the rule is kept.
		if (present && msg_count != CountSat) begin
			off = msg_count[5:0];
			block_bytes[off] = data;
			msg_count++;
			if (off == 63) compress_block();
		end
		if (eom) begin
			off = msg_count[5:0];
			block_bytes[off] = sha1_pkg::PadByte;
			for (int j = off + 1; j < 64; j++) block_bytes[j] = 8'h00;
			// No room for the length field: pad out this block first.
			if (off > 55) begin
				compress_block();
				for (int j = 0; j < 64; j++) block_bytes[j] = 8'h00;
			end
			bit_len = {msg_count, 3'b000};
			for (int j = 0; j < 8; j++) block_bytes[56+j] = bit_len[63-8*j -: 8];
			compress_block();
			for (int j = 0; j < 5; j++) begin
				dw.word = (known != '0) ? known[159-32*j -: 32] : chain[j];
				dw.idx = j[2:0];
				dw.is_last = (j == 4);
				pending_words.push_back(dw);
			end
			words_due += 5;
			restart_hash();
		end
	endtask

	// Offer one transaction. Valid stays high from the previous accepted
	// transaction when no gap is drawn, so it is never lowered and raised
	// within one time step.
	task automatic offer(logic [7:0] data, logic present, logic eom,
			logic [159:0] known = '0);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg_byte <= data;
		byte_present <= present;
		end_of_message <= eom;
		do @(posedge clk); while (msg_stall);
		absorb_item(data, present, eom, known);
	endtask

	// Send one message of the given length. Idle items (no byte, no end) are
	// mixed in now and then; the end travels with the last byte or alone.
	task automatic send_message(int unsigned len);
		bit end_alone;
		end_alone = (len == 0) || ($urandom_range(0, 2) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0) offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			offer(8'($urandom_range(0, 255)), 1'b1, !end_alone && i == len - 1);
			items_sent++;
		end
		if (end_alone) begin
			offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			items_sent++;
		end
	endtask

	// Directed rows. Known digests are those of the empty message and of
	// "abc"; all other rows are checked against the shadow hash.
	typedef struct {
		logic [7:0]   data;
		logic         present;
		logic         eom;
		logic [159:0] known;
	} stim_row_t;

	localparam logic [159:0] EmptyDigest = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
	localparam logic [159:0] AbcDigest = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

	stim_row_t directed[] = '{
		'{8'h00, 1'b0, 1'b1, EmptyDigest},     // empty message, end-only item
		'{8'h61, 1'b1, 1'b0, 160'h0},
		'{8'h62, 1'b1, 1'b0, 160'h0},
		'{8'h63, 1'b1, 1'b1, AbcDigest},       // "abc", end with the last byte
		'{8'hff, 1'b0, 1'b0, 160'h0},          // no byte and no end: ignored
		'{8'hA5, 1'b0, 1'b1, EmptyDigest},     // empty again, byte lane ignored
		'{8'h00, 1'b1, 1'b0, 160'h0},
		'{8'hff, 1'b1, 1'b1, 160'h0},
		'{8'h80, 1'b1, 1'b0, 160'h0},
		'{8'h55, 1'b0, 1'b0, 160'h0},          // idle item in mid-message
		'{8'h7f, 1'b1, 1'b0, 160'h0},
		'{8'h01, 1'b0, 1'b1, 160'h0}           // end-only item after bytes
	};

	// Result checker: values are read at the edge, before the block updates.
	always @(posedge clk) begin
		digest_out_t exp_w;
		if (arst_n && digest_valid && !digest_stall) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest transaction: word %h index %0d last %b",
						digest_word, word_index, last_word);
			end else begin
				exp_w = pending_words.pop_front();
				if (digest_word !== exp_w.word || word_index !== exp_w.idx ||
						last_word !== exp_w.is_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
							exp_w.word, exp_w.idx, exp_w.is_last,
							digest_word, word_index, last_word);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: one long hold-off first, so the block fills and stalls its
	// input, then a random wait before every digest transaction.
	initial begin
		int unsigned hold;
		digest_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		digest_stall <= 1'b1;
		repeat (LongHold) @(posedge clk);
		digest_stall <= 1'b0;
		forever begin
			do @(posedge clk); while (!(digest_valid && !digest_stall));
			hold = calm ? 0 : $urandom_range(0, 18);
			if (hold > 0) begin
				digest_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				digest_stall <= 1'b0;
			end
		end
	end

	int unsigned boundary_lens[] = '{0, 55, 56, 57, 63, 64, 65, 119, 120, 128};

	initial begin
		int unsigned len;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg_byte = '0;
		byte_present = 1'b0;
		end_of_message = 1'b0;
		restart_hash();
		for (int j = 0; j < 64; j++) block_bytes[j] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs into the long receiver hold-off.
		foreach (directed[i])
			offer(directed[i].data, directed[i].present, directed[i].eom, directed[i].known);

		// The sender pauses until every digest word is out.
		msg_valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (20) @(posedge clk);

		// Random messages: mostly short, some on the padding boundaries
		// (length field fits or spills into an extra block).
		items_sent = 0;
		while (items_sent < RandomItems || words_due < MinDigestWords) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 6)
				len = $urandom_range(1, 20);
			else
				len = boundary_lens[$urandom_range(0, boundary_lens.size() - 1)];
			send_message(len);
		end
		calm = 1'b0;

		@(posedge clk);
		msg_valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/sha1_pkg.sv
src/sha1_core.sv
src/sha1_message_digest.sv
tb/sha1_message_digest_tb.sv
